>>> src/vlsw_pkg.sv
// Shared constants and types for the video level scale and window dim block.
package vlsw_pkg;

  localparam int DATA_BITS     = 32;
  localparam int CFG_ADDR_BITS = 5;
  localparam int CFG_IDX_BITS  = 3;

  localparam logic [CFG_IDX_BITS-1:0] REG_LEVEL_LOW         = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_LEVEL_HIGH        = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_INTERLACED_LAYOUT = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_FIRST_FIELD_LINES = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_X_START    = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_X_END      = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_Y_START    = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_Y_END      = 3'd7;

  localparam int FIRST_FIELD_RESET = 313;

  localparam int GRAY_BITS  = 8;
  localparam int QUOT_BITS  = 8;
  localparam int DIV_STEPS  = 2;
  localparam int DIV_STAGES = QUOT_BITS / DIV_STEPS;

  localparam logic [GRAY_BITS-1:0] GRAY_MAX = 8'd255;

  // gray * 3 / 10 is taken as (gray * 615) >> 11, exact for every 8-bit gray.
  localparam int DIM_MUL_BITS = 10;
  localparam int PROD_BITS    = GRAY_BITS + DIM_MUL_BITS;
  localparam logic [DIM_MUL_BITS-1:0] DIM_MUL = 10'd615;
  localparam int DIM_SHIFT = 11;

  typedef struct packed {
    logic valid;
    logic zero;
    logic outside;
  } stage_flags_t;

endpackage

>>> src/vlsw_cfg.sv
// Configuration register file with its APB-style access port.
module vlsw_cfg
  import vlsw_pkg::*;
#(
  parameter int SAMPLE_BITS = 10,
  parameter int MAX_COLUMNS = 2048,
  parameter int MAX_ROWS    = 1024
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [CFG_ADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0]     pwdata,
  output logic [DATA_BITS-1:0]     prdata,
  output logic                     pready,
  output logic [SAMPLE_BITS-1:0]   level_low,
  output logic [SAMPLE_BITS-1:0]   level_high,
  output logic                     interlaced_layout,
  output logic [$clog2(MAX_ROWS):0]    first_field_lines,
  output logic [$clog2(MAX_COLUMNS):0] window_x_start,
  output logic [$clog2(MAX_COLUMNS):0] window_x_end,
  output logic [$clog2(MAX_ROWS):0]    window_y_start,
  output logic [$clog2(MAX_ROWS):0]    window_y_end
);

  localparam int WXW = $clog2(MAX_COLUMNS) + 1;
  localparam int WYW = $clog2(MAX_ROWS) + 1;

  logic                    wr;
  logic [CFG_IDX_BITS-1:0] idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[CFG_ADDR_BITS-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      level_low         <= '0;
      level_high        <= '1;
      interlaced_layout <= 1'b0;
      first_field_lines <= WYW'(FIRST_FIELD_RESET);
      window_x_start    <= '0;
      window_x_end      <= '0;
      window_y_start    <= '0;
      window_y_end      <= '0;
    end else if (wr) begin
      unique case (idx)
        REG_LEVEL_LOW:         level_low         <= pwdata[SAMPLE_BITS-1:0];
        REG_LEVEL_HIGH:        level_high        <= pwdata[SAMPLE_BITS-1:0];
        REG_INTERLACED_LAYOUT: interlaced_layout <= pwdata[0];
        REG_FIRST_FIELD_LINES: first_field_lines <= pwdata[WYW-1:0];
        REG_WINDOW_X_START:    window_x_start    <= pwdata[WXW-1:0];
        REG_WINDOW_X_END:      window_x_end      <= pwdata[WXW-1:0];
        REG_WINDOW_Y_START:    window_y_start    <= pwdata[WYW-1:0];
        REG_WINDOW_Y_END:      window_y_end      <= pwdata[WYW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_LEVEL_LOW:         prdata = DATA_BITS'(level_low);
      REG_LEVEL_HIGH:        prdata = DATA_BITS'(level_high);
      REG_INTERLACED_LAYOUT: prdata = DATA_BITS'(interlaced_layout);
      REG_FIRST_FIELD_LINES: prdata = DATA_BITS'(first_field_lines);
      REG_WINDOW_X_START:    prdata = DATA_BITS'(window_x_start);
      REG_WINDOW_X_END:      prdata = DATA_BITS'(window_x_end);
      REG_WINDOW_Y_START:    prdata = DATA_BITS'(window_y_start);
      REG_WINDOW_Y_END:      prdata = DATA_BITS'(window_y_end);
      default:               prdata = '0;
    endcase
  end

endmodule

>>> src/vlsw_front.sv
// First pipeline stage: level offset and scaled numerator, weaved line and window test.
module vlsw_front
  import vlsw_pkg::*;
#(
  parameter int SAMPLE_BITS = 10,
  parameter int MAX_COLUMNS = 2048,
  parameter int MAX_ROWS    = 1024
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [SAMPLE_BITS-1:0]     sample,
  input  logic [$clog2(MAX_COLUMNS)-1:0] column,
  input  logic [$clog2(MAX_ROWS)-1:0]    pix_row,
  input  logic [SAMPLE_BITS-1:0]     level_low,
  input  logic [SAMPLE_BITS-1:0]     level_high,
  input  logic                       interlaced_layout,
  input  logic [$clog2(MAX_ROWS):0]    first_field_lines,
  input  logic [$clog2(MAX_COLUMNS):0] window_x_start,
  input  logic [$clog2(MAX_COLUMNS):0] window_x_end,
  input  logic [$clog2(MAX_ROWS):0]    window_y_start,
  input  logic [$clog2(MAX_ROWS):0]    window_y_end,
  output stage_flags_t               flags,
  output logic [SAMPLE_BITS+QUOT_BITS-1:0] num
);

  localparam int NW  = SAMPLE_BITS + QUOT_BITS;
  localparam int CB  = $clog2(MAX_COLUMNS);
  localparam int RB  = $clog2(MAX_ROWS);

  logic [SAMPLE_BITS-1:0] diff;
  logic [NW-1:0]          num_next;
  logic                   zero;
  logic [RB:0]            row_ext;
  logic [RB:0]            row_off;
  logic [RB:0]            line;
  logic [CB:0]            col_ext;
  logic                   mask_en;
  logic                   row_on;
  logic                   col_on;

  always_comb begin
    zero     = (level_high <= level_low) || (sample <= level_low);
    diff     = sample - level_low;
    num_next = zero ? '0 : ((NW'(diff) << QUOT_BITS) - NW'(diff));

    row_ext = {1'b0, pix_row};
    row_off = row_ext - first_field_lines;
    if (interlaced_layout) begin
      line = row_ext;
    end else if (row_ext < first_field_lines) begin
      line = {pix_row, 1'b0};
    end else begin
      line = {row_off[RB-1:0], 1'b1};
    end

    col_ext = {1'b0, column};
    mask_en = (window_x_end > window_x_start) && (window_y_end > window_y_start);
    row_on  = (line >= window_y_start) && (line < window_y_end);
    col_on  = (col_ext >= window_x_start) && (col_ext < window_x_end);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flags.valid <= 1'b0;
    end else if (en) begin
      flags.valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      flags.zero    <= zero;
      flags.outside <= mask_en && !(row_on && col_on);
      num           <= num_next;
    end
  end

endmodule

>>> src/vlsw_div_stage.sv
// One restoring division stage that settles two quotient bits of the scaled level.
module vlsw_div_stage
  import vlsw_pkg::*;
#(
  parameter int SAMPLE_BITS = 10,
  parameter int TOP_BIT     = 7
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic [SAMPLE_BITS-1:0]           divisor,
  input  stage_flags_t                     in_flags,
  input  logic [SAMPLE_BITS+QUOT_BITS-1:0] in_rem,
  input  logic [QUOT_BITS-1:0]             in_quot,
  output stage_flags_t                     flags,
  output logic [SAMPLE_BITS+QUOT_BITS-1:0] rem,
  output logic [QUOT_BITS-1:0]             quot
);

  localparam int NW = SAMPLE_BITS + QUOT_BITS;

  logic [NW-1:0]        rem_next;
  logic [QUOT_BITS-1:0] quot_next;
  logic [NW-1:0]        shifted;

  always_comb begin
    rem_next  = in_rem;
    quot_next = in_quot;
    shifted   = '0;
    for (int j = 0; j < DIV_STEPS; j++) begin
      shifted = NW'(divisor) << (TOP_BIT - j);
      if (rem_next >= shifted) begin
        rem_next               = rem_next - shifted;
        quot_next[TOP_BIT - j] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flags.valid <= 1'b0;
    end else if (en) begin
      flags.valid <= in_flags.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      flags.zero    <= in_flags.zero;
      flags.outside <= in_flags.outside;
      rem           <= rem_next;
      quot          <= quot_next;
    end
  end

endmodule

>>> src/vlsw_dim.sv
// Output stage: saturation, window dimming and the output register.
module vlsw_dim
  import vlsw_pkg::*;
#(
  parameter int SAMPLE_BITS = 10
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic [SAMPLE_BITS-1:0]           divisor,
  input  stage_flags_t                     in_flags,
  input  logic [SAMPLE_BITS+QUOT_BITS-1:0] in_rem,
  input  logic [QUOT_BITS-1:0]             in_quot,
  output logic                             out_valid,
  output logic [GRAY_BITS-1:0]             gray,
  output logic                             dimmed
);

  localparam int NW = SAMPLE_BITS + QUOT_BITS;

  logic                 sat;
  logic [GRAY_BITS-1:0] base;
  logic [PROD_BITS-1:0] prod;
  logic [GRAY_BITS-1:0] gray_next;

  // A remainder still at or above the divisor means the quotient passed 255.
  always_comb begin
    sat = in_rem >= NW'(divisor);
    if (in_flags.zero) begin
      base = '0;
    end else if (sat) begin
      base = GRAY_MAX;
    end else begin
      base = in_quot;
    end
    prod      = PROD_BITS'(base) * PROD_BITS'(DIM_MUL);
    gray_next = in_flags.outside ? GRAY_BITS'(prod >> DIM_SHIFT) : base;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_flags.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      gray   <= gray_next;
      dimmed <= in_flags.outside;
    end
  end

endmodule

>>> src/video_level_scale_and_window_dim.sv
// Top level of the video level scale and window dim block.
// One beat enters per clock while the pipeline is not held: a front stage forms
// the scaled numerator and the window test, four stages each settle two quotient bits of
// the division by the configured level span, and an output stage saturates, dims and
// registers the result. When the output beat is stalled the whole pipeline holds, so
// in_stall follows out_stall while a result waits. Configuration is written through the
// APB-style port at byte address 4 times the register index.
module video_level_scale_and_window_dim
  import vlsw_pkg::*;
#(
  parameter int SAMPLE_BITS = 10,
  parameter int MAX_COLUMNS = 2048,
  parameter int MAX_ROWS    = 1024
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [CFG_ADDR_BITS-1:0]       paddr,
  input  logic [DATA_BITS-1:0]           pwdata,
  output logic [DATA_BITS-1:0]           prdata,
  output logic                           pready,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [SAMPLE_BITS-1:0]         sample,
  input  logic [$clog2(MAX_COLUMNS)-1:0] column,
  input  logic [$clog2(MAX_ROWS)-1:0]    pix_row,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [GRAY_BITS-1:0]           gray,
  output logic                           dimmed
);

  localparam int NW = SAMPLE_BITS + QUOT_BITS;

  logic [SAMPLE_BITS-1:0]          level_low;
  logic [SAMPLE_BITS-1:0]          level_high;
  logic                            interlaced_layout;
  logic [$clog2(MAX_ROWS):0]       first_field_lines;
  logic [$clog2(MAX_COLUMNS):0]    window_x_start;
  logic [$clog2(MAX_COLUMNS):0]    window_x_end;
  logic [$clog2(MAX_ROWS):0]       window_y_start;
  logic [$clog2(MAX_ROWS):0]       window_y_end;
  logic [SAMPLE_BITS-1:0]          span;
  logic                            en;

  stage_flags_t                    flags [DIV_STAGES+1];
  logic [NW-1:0]                   rem   [DIV_STAGES+1];
  logic [QUOT_BITS-1:0]            quot  [DIV_STAGES+1];

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;
  assign span     = level_high - level_low;
  assign quot[0]  = '0;

  vlsw_cfg #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .MAX_COLUMNS(MAX_COLUMNS),
    .MAX_ROWS   (MAX_ROWS)
  ) u_cfg (
    .clk              (clk),
    .rst              (rst),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .level_low        (level_low),
    .level_high       (level_high),
    .interlaced_layout(interlaced_layout),
    .first_field_lines(first_field_lines),
    .window_x_start   (window_x_start),
    .window_x_end     (window_x_end),
    .window_y_start   (window_y_start),
    .window_y_end     (window_y_end)
  );

  vlsw_front #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .MAX_COLUMNS(MAX_COLUMNS),
    .MAX_ROWS   (MAX_ROWS)
  ) u_front (
    .clk              (clk),
    .rst              (rst),
    .en               (en),
    .in_valid         (in_valid),
    .sample           (sample),
    .column           (column),
    .pix_row          (pix_row),
    .level_low        (level_low),
    .level_high       (level_high),
    .interlaced_layout(interlaced_layout),
    .first_field_lines(first_field_lines),
    .window_x_start   (window_x_start),
    .window_x_end     (window_x_end),
    .window_y_start   (window_y_start),
    .window_y_end     (window_y_end),
    .flags            (flags[0]),
    .num              (rem[0])
  );

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    vlsw_div_stage #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .TOP_BIT    (QUOT_BITS - 1 - k * DIV_STEPS)
    ) u_div (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .divisor (span),
      .in_flags(flags[k]),
      .in_rem  (rem[k]),
      .in_quot (quot[k]),
      .flags   (flags[k+1]),
      .rem     (rem[k+1]),
      .quot    (quot[k+1])
    );
  end

  vlsw_dim #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_dim (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .divisor  (span),
    .in_flags (flags[DIV_STAGES]),
    .in_rem   (rem[DIV_STAGES]),
    .in_quot  (quot[DIV_STAGES]),
    .out_valid(out_valid),
    .gray     (gray),
    .dimmed   (dimmed)
  );

endmodule

>>> test/video_level_scale_and_window_dim_tb.sv
`timescale 1ns / 1ps
// Testbench for the video level scaler: directed table, then random pixels checked by a predictor.
module video_level_scale_and_window_dim_tb
  import vlsw_pkg::*;
();

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 300;
  localparam int HOLD_AFTER     = 400;
  localparam int PHASES         = 10;
  localparam int PHASE_PIXELS   = 120;

  typedef struct packed {
    logic [7:0] gray;
    logic       dimmed;
  } pixel_result_t;

  typedef enum logic {STEP_PIXEL, STEP_WRITE} step_kind_t;

  typedef struct {
    step_kind_t                kind;
    logic [CFG_IDX_BITS-1:0]   idx;
    logic [DATA_BITS-1:0]      value;
    logic [9:0]                s;
    logic [10:0]               c;
    logic [9:0]                r;
    logic                      known;
    pixel_result_t             want;
  } stim_row_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [CFG_ADDR_BITS-1:0] paddr = '0;
  logic [DATA_BITS-1:0]     pwdata = '0;
  logic [DATA_BITS-1:0]     prdata;
  logic                     pready;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [9:0]               sample = '0;
  logic [10:0]              column = '0;
  logic [9:0]               pix_row = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [7:0]               gray;
  logic                     dimmed;

  logic [9:0]  cfg_low = 10'd0;
  logic [9:0]  cfg_high = 10'd1023;
  logic        cfg_interlaced = 1'b0;
  logic [10:0] cfg_ffl = 11'd313;
  logic [11:0] cfg_wxs = '0;
  logic [11:0] cfg_wxe = '0;
  logic [10:0] cfg_wys = '0;
  logic [10:0] cfg_wye = '0;

  pixel_result_t expected_pixels[$];
  stim_row_t     directed_rows[$];

  int errors = 0;
  int n_pixels = 0;
  int n_results = 0;
  int n_dimmed = 0;
  int n_writes = 0;
  int burst_left = 0;
  int hold_left = 0;
  bit hold_done = 0;
  int stall_cycle = 0;
  int idle_cycles = 0;

  video_level_scale_and_window_dim u_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .sample(sample), .column(column), .pix_row(pix_row),
    .out_valid(out_valid), .out_stall(out_stall),
    .gray(gray), .dimmed(dimmed)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic pixel_result_t predict_pixel(input logic [9:0] s, input logic [10:0] c,
                                                  input logic [9:0] r);
    pixel_result_t res;
    int unsigned   span;
    int unsigned   diff;
    int unsigned   q;
    int unsigned   g;
    int unsigned   wl;
    g = 0;
    if (cfg_high > cfg_low && s > cfg_low) begin
      span = int'(cfg_high) - int'(cfg_low);
      diff = int'(s) - int'(cfg_low);
      q = (diff * 255) / span;
      g = (q > 255) ? 255 : q;
    end
    res.dimmed = 1'b0;
    if (cfg_wxe > cfg_wxs && cfg_wye > cfg_wys) begin
      if (cfg_interlaced) begin
        wl = r;
      end else if (r < cfg_ffl) begin
        wl = int'(r) * 2;
      end else begin
        wl = (int'(r) - int'(cfg_ffl)) * 2 + 1;
      end
      if (!(wl >= cfg_wys && wl < cfg_wye && c >= cfg_wxs && c < cfg_wxe)) begin
        g = g * 3 / 10;
        res.dimmed = 1'b1;
      end
    end
    res.gray = g[7:0];
    return res;
  endfunction

  function automatic int unsigned pick_near(input int center, input int maxv);
    int v;
    v = center + int'($urandom_range(0, 6)) - 3;
    if (v < 0) v = 0;
    if (v > maxv) v = maxv;
    return v;
  endfunction

  function automatic void row_pixel(input int s, input int c, input int r, input int known,
                                    input int g, input int d);
    stim_row_t row;
    row.kind = STEP_PIXEL;
    row.idx = '0;
    row.value = '0;
    row.s = 10'(s);
    row.c = 11'(c);
    row.r = 10'(r);
    row.known = (known != 0);
    row.want.gray = 8'(g);
    row.want.dimmed = (d != 0);
    directed_rows = {directed_rows, row};
  endfunction

  function automatic void row_write(input logic [CFG_IDX_BITS-1:0] idx, input int value);
    stim_row_t row;
    row.kind = STEP_WRITE;
    row.idx = idx;
    row.value = DATA_BITS'(value);
    row.s = '0;
    row.c = '0;
    row.r = '0;
    row.known = 1'b0;
    row.want = '0;
    directed_rows = {directed_rows, row};
  endfunction

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [DATA_BITS-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_LEVEL_LOW:         cfg_low = value[9:0];
      REG_LEVEL_HIGH:        cfg_high = value[9:0];
      REG_INTERLACED_LAYOUT: cfg_interlaced = value[0];
      REG_FIRST_FIELD_LINES: cfg_ffl = value[10:0];
      REG_WINDOW_X_START:    cfg_wxs = value[11:0];
      REG_WINDOW_X_END:      cfg_wxe = value[11:0];
      REG_WINDOW_Y_START:    cfg_wys = value[10:0];
      REG_WINDOW_Y_END:      cfg_wye = value[10:0];
      default: ;
    endcase
    n_writes++;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_pixel(input logic [9:0] s, input logic [10:0] c, input logic [9:0] r,
                            input logic known, input pixel_result_t want);
    pixel_result_t predicted;
    int            gap;
    in_valid <= 1'b1;
    sample <= s;
    column <= c;
    pix_row <= r;
    do @(posedge clk); while (in_stall);
    if (known) begin
      predicted = want;
    end else begin
      predicted = predict_pixel(s, c, r);
    end
    expected_pixels = {expected_pixels, predicted};
    n_pixels++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 5) == 0) ? 150 : $urandom_range(1, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic settle_pipe();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_pixels.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin : result_check
    pixel_result_t want;
    if (!rst) begin
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, idle_cycles);
        $display("video_level_scale_and_window_dim: mismatch");
        $finish;
      end
      if (out_valid && !out_stall) begin
        n_results++;
        if (dimmed) n_dimmed++;
        if (expected_pixels.size() == 0) begin
          $display("%0t: result gray=%0d dimmed=%0d arrived with nothing expected",
                   $time, gray, dimmed);
          errors++;
        end else begin
          want = expected_pixels.pop_front();
          if (gray !== want.gray) begin
            $display("%0t: gray expected %0d, got %0d", $time, want.gray, gray);
            errors++;
          end
          if (dimmed !== want.dimmed) begin
            $display("%0t: dimmed expected %0d, got %0d", $time, want.dimmed, dimmed);
            errors++;
          end
        end
      end
      stall_cycle++;
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (!hold_done && n_results >= HOLD_AFTER) begin
        hold_done = 1;
        hold_left = HOLD_CYCLES;
        out_stall <= 1'b1;
      end else begin
        case ((stall_cycle / 97) % 4)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= stall_cycle[0];
        endcase
      end
    end
  end

  initial begin
    int lo, hi, il, ffl, xs, xe, ys, ye;
    int s, c, r;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    row_pixel(0, 0, 0, 1, 0, 0);
    row_pixel(1023, 2047, 1023, 1, 255, 0);
    row_pixel(512, 1, 700, 0, 0, 0);
    row_write(REG_LEVEL_LOW, 100);
    row_write(REG_LEVEL_HIGH, 100);
    row_pixel(1023, 0, 0, 1, 0, 0);
    row_write(REG_LEVEL_HIGH, 50);
    row_pixel(500, 3, 3, 1, 0, 0);
    row_write(REG_LEVEL_HIGH, 612);
    row_pixel(50, 7, 7, 1, 0, 0);
    row_pixel(100, 7, 7, 1, 0, 0);
    row_pixel(1000, 7, 7, 1, 255, 0);
    row_pixel(356, 7, 7, 0, 0, 0);
    row_pixel(101, 7, 7, 0, 0, 0);
    row_write(REG_WINDOW_X_START, 100);
    row_write(REG_WINDOW_X_END, 200);
    row_write(REG_WINDOW_Y_START, 10);
    row_write(REG_WINDOW_Y_END, 20);
    row_pixel(1000, 100, 5, 1, 255, 0);
    row_pixel(1000, 199, 9, 1, 255, 0);
    row_pixel(1000, 200, 5, 1, 76, 1);
    row_pixel(1000, 99, 5, 1, 76, 1);
    row_pixel(1000, 150, 10, 1, 76, 1);
    row_pixel(1000, 150, 313, 0, 0, 0);
    row_pixel(700, 150, 318, 0, 0, 0);
    row_write(REG_INTERLACED_LAYOUT, 1);
    row_pixel(1000, 150, 19, 1, 255, 0);
    row_pixel(1000, 150, 20, 1, 76, 1);
    row_write(REG_WINDOW_X_END, 100);
    row_pixel(1000, 0, 0, 1, 255, 0);
    row_write(REG_WINDOW_X_START, 0);
    row_write(REG_WINDOW_X_END, 4095);
    row_write(REG_WINDOW_Y_START, 0);
    row_write(REG_WINDOW_Y_END, 2047);
    row_pixel(1023, 2047, 1023, 1, 255, 0);
    row_write(REG_INTERLACED_LAYOUT, 0);
    row_write(REG_FIRST_FIELD_LINES, 0);
    row_pixel(600, 5, 0, 0, 0, 0);
    row_write(REG_FIRST_FIELD_LINES, 1024);
    row_pixel(600, 5, 1023, 0, 0, 0);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == STEP_WRITE) begin
        settle_pipe();
        write_reg(directed_rows[i].idx, directed_rows[i].value);
      end else begin
        send_pixel(directed_rows[i].s, directed_rows[i].c, directed_rows[i].r,
                   directed_rows[i].known, directed_rows[i].want);
      end
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin
          lo = 0; hi = 1023; il = 0; ffl = 313; xs = 0; xe = 0; ys = 0; ye = 0;
        end
        1: begin
          lo = 1023; hi = 0; il = 0; ffl = 1024; xs = 0; xe = 4095; ys = 0; ye = 2047;
        end
        2: begin
          lo = 1022; hi = 1023; il = 1; ffl = 2047; xs = 2047; xe = 4095; ys = 1023; ye = 1024;
        end
        3: begin
          lo = 0; hi = 1; il = 0; ffl = 0; xs = 4094; xe = 4095; ys = 0; ye = 2047;
        end
        default: begin
          lo = $urandom_range(0, 900);
          hi = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023)
                                           : lo + $urandom_range(1, 1023 - lo);
          il = $urandom_range(0, 1);
          ffl = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2047) : $urandom_range(200, 700);
          xs = $urandom_range(0, 1800);
          xe = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4095) : xs + $urandom_range(1, 400);
          ys = $urandom_range(0, 1600);
          ye = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2047) : ys + $urandom_range(1, 400);
        end
      endcase
      settle_pipe();
      write_reg(REG_LEVEL_LOW, lo);
      write_reg(REG_LEVEL_HIGH, hi);
      write_reg(REG_INTERLACED_LAYOUT, il);
      write_reg(REG_FIRST_FIELD_LINES, ffl);
      write_reg(REG_WINDOW_X_START, xs);
      write_reg(REG_WINDOW_X_END, xe);
      write_reg(REG_WINDOW_Y_START, ys);
      write_reg(REG_WINDOW_Y_END, ye);
      for (int k = 0; k < PHASE_PIXELS; k++) begin
        case ($urandom_range(0, 3))
          0: s = pick_near(cfg_low, 1023);
          1: s = pick_near(cfg_high, 1023);
          default: s = $urandom_range(0, 1023);
        endcase
        case ($urandom_range(0, 2))
          0: c = pick_near(cfg_wxs, 2047);
          1: c = pick_near(cfg_wxe, 2047);
          default: c = $urandom_range(0, 2047);
        endcase
        case ($urandom_range(0, 5))
          0: r = pick_near(cfg_ffl, 1023);
          1: r = pick_near(cfg_interlaced ? cfg_wys : cfg_wys / 2, 1023);
          2: r = pick_near(cfg_interlaced ? cfg_wye : cfg_wye / 2, 1023);
          3: r = pick_near(cfg_ffl + cfg_wys / 2, 1023);
          default: r = $urandom_range(0, 1023);
        endcase
        send_pixel(10'(s), 11'(c), 10'(r), 1'b0, '0);
      end
    end

    settle_pipe();
    repeat (10) @(posedge clk);
    $display("Sent %0d pixels across %0d register writes, including level and window extremes.",
             n_pixels, n_writes);
    $display("Checked %0d results, %0d of them dimmed, with %0d errors.",
             n_results, n_dimmed, errors);
    if (errors == 0) begin
      $display("video_level_scale_and_window_dim: match");
    end else begin
      $display("video_level_scale_and_window_dim: mismatch");
    end
    $finish;
  end

endmodule

>>> files.f
src/vlsw_pkg.sv
src/vlsw_cfg.sv
src/vlsw_front.sv
src/vlsw_div_stage.sv
src/vlsw_dim.sv
src/video_level_scale_and_window_dim.sv
test/video_level_scale_and_window_dim_tb.sv
